// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the chunk cache modules.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int RESULT_CAP   = 64;
  localparam logic [31:0] BUDGET_RESET = 32'd2097152;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] stream_id;
    logic [31:0] query_time;
    logic [31:0] chunk_start;
    logic [31:0] chunk_span;
    logic [23:0] chunk_bytes;
    logic [31:0] elapsed;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        evicted;
    logic [15:0] evicted_stream;
    logic [31:0] evicted_start;
    logic        table_full;
    logic [31:0] bytes_used;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] stream;
    logic [31:0] start;
    logic [31:0] span;
    logic [23:0] bytes;
    logic [31:0] idle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bbc_core.sv =====
// ----------------------------------------------------------------------------
// bbc_core
// Slot scan sequencer: one entry read per cycle through a shared compare/add
// datapath, serving lookup, insert, tick aging and eviction passes.
// ----------------------------------------------------------------------------
module bbc_core #(
  parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bbc_pkg::req_t item,
  input  logic [31:0]   max_bytes,
  output logic          idle,
  output logic          res_vld,
  input  logic          res_take,
  output bbc_pkg::rsp_t res
);
  import bbc_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = $clog2(RESULT_CAP + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_CHK, S_EVDONE, S_EVAPPLY, S_FIN, S_EMIT
  } state_t;

  typedef enum logic [1:0] {OP_LOOK, OP_INS, OP_UPD, OP_EVS} op_t;

  state_t          state, ret;
  op_t             op;
  req_t            it;
  logic [AW:0]     cnt;
  logic            p_vld;
  logic [AW-1:0]   p_idx;
  logic [31:0]     hits, misses, total;
  logic            found;
  logic [AW-1:0]   best;
  logic [31:0]     bidle;
  logic [15:0]     bstream;
  logic [31:0]     bstart;
  logic [23:0]     bbytes;
  rsp_t            pend, pend_last, base;
  rsp_t            res_hit, res_miss, res_ins, res_full, ev_item;
  logic            pend_vld;
  logic [NW-1:0]   n;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata, q;
  logic [ENTRY_W-1:0] rdata;

  logic            issue, scan_end, is_match, scan_stop;
  logic [32:0]     span_end, idle_sum, tot_sum;
  logic [31:0]     idle_sat, tot_sat, tot_sub;

  bbc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    q        = entry_t'(rdata);
    issue    = (state == S_SCAN) && (cnt < (AW+1)'(SLOTS));
    scan_end = p_vld && (p_idx == AW'(SLOTS - 1));
    span_end = {1'b0, q.start} + {1'b0, q.span};
    is_match = q.valid && (q.stream == it.stream_id) && (it.query_time >= q.start)
               && ({1'b0, it.query_time} < span_end);
    scan_stop = p_vld && (scan_end || ((op == OP_LOOK) && is_match)
                || ((op == OP_INS) && !q.valid));
    idle_sum = {1'b0, q.idle} + {1'b0, it.elapsed};
    idle_sat = idle_sum[32] ? 32'hFFFF_FFFF : idle_sum[31:0];
    tot_sum  = {1'b0, total} + {9'd0, it.chunk_bytes};
    tot_sat  = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
    tot_sub  = ({8'd0, bbytes} > total) ? 32'd0 : total - {8'd0, bbytes};

    base            = '0;
    base.bytes_used = total;
    base.hit_count  = hits;
    base.miss_count = misses;
    base.last       = 1'b1;
    pend_last       = pend;
    pend_last.last  = 1'b1;

    res_hit           = base;
    res_hit.hit       = 1'b1;
    res_hit.slot      = 6'(p_idx);
    res_hit.hit_count = hits + 32'd1;
    res_miss            = base;
    res_miss.miss_count = misses + 32'd1;
    res_ins            = base;
    res_ins.slot       = 6'(p_idx);
    res_ins.bytes_used = tot_sat;
    res_full            = base;
    res_full.table_full = 1'b1;

    ev_item                = '0;
    ev_item.slot           = 6'(best);
    ev_item.evicted        = 1'b1;
    ev_item.evicted_stream = bstream;
    ev_item.evicted_start  = bstart;
    ev_item.bytes_used     = tot_sub;
    ev_item.hit_count      = hits;
    ev_item.miss_count     = misses;

    we    = 1'b0;
    waddr = p_idx;
    wdata = q;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt[AW-1:0];
        wdata = '0;
      end
      S_SCAN: begin
        if (p_vld) begin
          case (op)
            OP_LOOK: begin
              we         = is_match;
              wdata.idle = '0;
            end
            OP_INS: begin
              we    = !q.valid;
              wdata = '{valid: 1'b1, stream: it.stream_id, start: it.chunk_start,
                        span: it.chunk_span, bytes: it.chunk_bytes, idle: 32'd0};
            end
            OP_UPD: begin
              we         = q.valid;
              wdata.idle = idle_sat;
            end
            default: we = 1'b0;
          endcase
        end
      end
      S_EVAPPLY: begin
        we    = 1'b1;
        waddr = best;
        wdata = '0;
      end
      default: we = 1'b0;
    endcase
  end

  assign idle    = (state == S_IDLE);
  assign res_vld = (state == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      ret      <= S_IDLE;
      cnt      <= '0;
      p_vld    <= 1'b0;
      hits     <= '0;
      misses   <= '0;
      total    <= '0;
      pend_vld <= 1'b0;
      n        <= '0;
      found    <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt[AW-1:0] == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            it    <= item;
            cnt   <= '0;
            p_vld <= 1'b0;
            ret   <= S_IDLE;
            case (item.kind)
              KIND_LOOKUP: begin
                op    <= OP_LOOK;
                state <= S_SCAN;
              end
              KIND_INSERT: begin
                op    <= OP_INS;
                state <= S_SCAN;
              end
              KIND_TICK: begin
                hits     <= '0;
                misses   <= '0;
                n        <= '0;
                pend_vld <= 1'b0;
                op       <= OP_UPD;
                state    <= S_SCAN;
              end
              default: begin
                res   <= base;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          p_vld <= issue && !scan_stop;
          p_idx <= cnt[AW-1:0];
          if (p_vld) begin
            case (op)
              OP_LOOK: begin
                if (is_match) begin
                  hits  <= hits + 32'd1;
                  res   <= res_hit;
                  state <= S_EMIT;
                end else if (scan_end) begin
                  misses <= misses + 32'd1;
                  res    <= res_miss;
                  state  <= S_EMIT;
                end
              end
              OP_INS: begin
                if (!q.valid) begin
                  total <= tot_sat;
                  res   <= res_ins;
                  state <= S_EMIT;
                end else if (scan_end) begin
                  res   <= res_full;
                  state <= S_EMIT;
                end
              end
              OP_UPD: begin
                if (scan_end) begin
                  state <= S_CHK;
                end
              end
              default: begin
                if (q.valid && (!found || q.idle > bidle)) begin
                  found   <= 1'b1;
                  best    <= p_idx;
                  bidle   <= q.idle;
                  bstream <= q.stream;
                  bstart  <= q.start;
                  bbytes  <= q.bytes;
                end
                if (scan_end) begin
                  state <= S_EVDONE;
                end
              end
            endcase
          end
        end
        S_CHK: begin
          if ((total > max_bytes) && (n < NW'(RESULT_CAP))) begin
            cnt   <= '0;
            found <= 1'b0;
            op    <= OP_EVS;
            state <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_EVDONE: begin
          if (!found) begin
            state <= S_FIN;
          end else if (pend_vld) begin
            res   <= pend;
            ret   <= S_EVAPPLY;
            state <= S_EMIT;
          end else begin
            state <= S_EVAPPLY;
          end
        end
        S_EVAPPLY: begin
          total    <= tot_sub;
          pend     <= ev_item;
          pend_vld <= 1'b1;
          n        <= n + 1'b1;
          state    <= S_CHK;
        end
        S_FIN: begin
          res      <= pend_vld ? pend_last : base;
          pend_vld <= 1'b0;
          ret      <= S_IDLE;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cap: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(RESULT_CAP)) else $error("eviction count above cap");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("item started while busy");
  a_take_once: assert property (@(posedge clk) disable iff (rst)
    res_take |=> !res_vld) else $error("result offered twice");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT) |-> !we) else $error("write while not scanning");
`endif

endmodule

// ===== rtl/byte_budget_chunk_cache_unit.sv =====
// ----------------------------------------------------------------------------
// byte_budget_chunk_cache_unit
// Size-bounded tag cache of decoded chunks with idle-time eviction.
// ----------------------------------------------------------------------------
// After reset the unit clears every entry of its slot memory and holds
// req_stall high meanwhile. Each item is handled alone: a lookup or insert
// scans the slot memory one entry per cycle, stopping early on a hit or a
// free slot; a tick ages the timers in one full scan and then runs one
// full scan per eviction, at most 64 evictions. The single memory read port
// serialises these scans. Results pass through an output register, so a
// stalled result never blocks the scan until the next one.
module byte_budget_chunk_cache_unit #(
  parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bbc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bbc_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import bbc_pkg::*;

  logic        idle, start, res_vld, res_take;
  rsp_t        res;
  logic [31:0] max_bytes;

  assign req_stall = !idle;
  assign start     = req_valid && idle;
  assign cfg_ready = 1'b1;
  assign res_take  = res_vld && (!rsp_valid || !rsp_stall);

  bbc_core #(.SLOTS(SLOTS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (req),
    .max_bytes (max_bytes),
    .idle      (idle),
    .res_vld   (res_vld),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= BUDGET_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bytes <= cfg_data;
      end
      if (res_take) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/byte_budget_chunk_cache_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_chunk_cache_unit_tb
// Drives lookups, inserts and ticks into the chunk cache and checks each
// result item against a cycle-free model of the slot table and eviction.
// ----------------------------------------------------------------------------
module byte_budget_chunk_cache_unit_tb;
  import bbc_pkg::*;

  localparam int NSLOT = 64;

  class chunk_scoreboard;
    logic [31:0] budget;
    bit          vld[NSLOT];
    logic [15:0] strm[NSLOT];
    logic [31:0] st[NSLOT];
    logic [31:0] sp[NSLOT];
    logic [23:0] byt[NSLOT];
    logic [31:0] idl[NSLOT];
    logic [31:0] total, hits, misses;
    rsp_t        pending[$];
    int          errors;
    int          checked;

    function new();
      budget = BUDGET_RESET;
      total = 0; hits = 0; misses = 0;
      errors = 0; checked = 0;
      foreach (vld[i]) vld[i] = 0;
    endfunction

    function rsp_t blank();
      rsp_t r;
      r = '0;
      r.bytes_used = total;
      r.hit_count = hits;
      r.miss_count = misses;
      return r;
    endfunction

    function void note_request(req_t q);
      rsp_t r;
      int i, n, best;
      bit found;
      logic [32:0] e, v;
      logic [31:0] bi;
      if (q.kind == KIND_LOOKUP) begin
        found = 0;
        for (i = 0; i < NSLOT; i++) begin
          e = {1'b0, st[i]} + {1'b0, sp[i]};
          if (vld[i] && strm[i] == q.stream_id && q.query_time >= st[i] &&
              {1'b0, q.query_time} < e) begin
            found = 1;
            break;
          end
        end
        if (found) begin
          idl[i] = 0;
          hits++;
        end else misses++;
        r = blank();
        r.hit = found;
        r.slot = found ? i[5:0] : 6'd0;
        r.last = 1;
        pending.push_back(r);
      end else if (q.kind == KIND_INSERT) begin
        found = 0;
        for (i = 0; i < NSLOT; i++)
          if (!vld[i]) begin
            found = 1;
            break;
          end
        if (found) begin
          vld[i] = 1; strm[i] = q.stream_id; st[i] = q.chunk_start;
          sp[i] = q.chunk_span; byt[i] = q.chunk_bytes; idl[i] = 0;
          v = {1'b0, total} + q.chunk_bytes;
          total = v[32] ? 32'hFFFFFFFF : v[31:0];
        end
        r = blank();
        r.slot = found ? i[5:0] : 6'd0;
        r.table_full = !found;
        r.last = 1;
        pending.push_back(r);
      end else if (q.kind == KIND_TICK) begin
        hits = 0; misses = 0; n = 0;
        for (i = 0; i < NSLOT; i++)
          if (vld[i]) begin
            v = {1'b0, idl[i]} + q.elapsed;
            idl[i] = v[32] ? 32'hFFFFFFFF : v[31:0];
          end
        while (total > budget && n < RESULT_CAP) begin
          found = 0; best = 0; bi = 0;
          for (i = 0; i < NSLOT; i++)
            if (vld[i] && (!found || idl[i] > bi)) begin
              found = 1; best = i; bi = idl[i];
            end
          if (!found) break;
          vld[best] = 0;
          total = byt[best] > total ? 32'd0 : total - byt[best];
          r = blank();
          r.slot = best[5:0];
          r.evicted = 1;
          r.evicted_stream = strm[best];
          r.evicted_start = st[best];
          pending.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = blank();
          r.last = 1;
          pending.push_back(r);
        end else pending[$].last = 1;
      end else begin
        r = blank();
        r.last = 1;
        pending.push_back(r);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t x;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result item", got, '0);
        return;
      end
      x = pending.pop_front();
      if (got.hit !== x.hit) report_mismatch("hit", got, x);
      if (got.slot !== x.slot) report_mismatch("slot", got, x);
      if (got.evicted !== x.evicted) report_mismatch("evicted", got, x);
      if (got.evicted_stream !== x.evicted_stream) report_mismatch("evicted_stream", got, x);
      if (got.evicted_start !== x.evicted_start) report_mismatch("evicted_start", got, x);
      if (got.table_full !== x.table_full) report_mismatch("table_full", got, x);
      if (got.bytes_used !== x.bytes_used) report_mismatch("bytes_used", got, x);
      if (got.hit_count !== x.hit_count) report_mismatch("hit_count", got, x);
      if (got.miss_count !== x.miss_count) report_mismatch("miss_count", got, x);
      if (got.last !== x.last) report_mismatch("last", got, x);
    endfunction

    function void report_mismatch(string what, rsp_t got, rsp_t want);
      errors++;
      if (errors <= 30)
        $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic req_valid = 0, rsp_stall = 0, cfg_valid = 0;
  logic [31:0] cfg_data = 0;
  req_t req = '0;
  logic req_stall, rsp_valid, cfg_ready;
  rsp_t rsp;

  int send_idle = 0, recv_stall = 0;
  int items_sent = 0;
  chunk_scoreboard sb;

  byte_budget_chunk_cache_unit i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      rsp_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  task automatic send_item(req_t q);
    while (($urandom_range(99) < send_idle)) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(q);
    items_sent++;
  endtask

  task automatic write_budget(logic [31:0] val);
    int n;
    req_valid <= 0;
    n = 0;
    while (sb.pending.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (8500) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.budget = val;
  endtask

  function automatic req_t make_req(logic [1:0] k, logic [15:0] s, logic [31:0] a,
                                    logic [31:0] b, logic [31:0] c, logic [23:0] d,
                                    logic [31:0] e);
    req_t q;
    q.kind = k; q.stream_id = s; q.query_time = a; q.chunk_start = b;
    q.chunk_span = c; q.chunk_bytes = d; q.elapsed = e;
    return q;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int p;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    p = $urandom_range(99);
    q.stream_id = ($urandom_range(3) == 0) ? q.stream_id : 16'($urandom_range(3));
    if (p < 40) begin
      q.kind = KIND_LOOKUP;
      if ($urandom_range(1)) q.query_time = $urandom_range(2000);
    end else if (p < 80) begin
      q.kind = KIND_INSERT;
      if ($urandom_range(1)) begin
        q.chunk_start = $urandom_range(1000);
        q.chunk_span = $urandom_range(1000);
      end
      if ($urandom_range(2) != 0) q.chunk_bytes = 24'($urandom_range(200000));
    end else if (p < 97) begin
      q.kind = KIND_TICK;
      if ($urandom_range(3) != 0) q.elapsed = $urandom_range(5000);
    end else q.kind = 2'd3;
    return q;
  endfunction

  initial begin
    int ph, k;
    logic [31:0] budgets[4];
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed
    send_item(make_req(KIND_LOOKUP, 16'h0, 32'h0, 0, 0, 0, 0));
    send_item(make_req(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send_item(make_req(KIND_INSERT, 16'hFFFF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 0));
    send_item(make_req(KIND_INSERT, 16'h1, 0, 32'd10, 32'd0, 24'd5, 0));
    send_item(make_req(KIND_INSERT, 16'h1, 0, 32'd100, 32'd50, 24'd1000, 0));
    send_item(make_req(KIND_LOOKUP, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0));
    send_item(make_req(KIND_LOOKUP, 16'hFFFF, 32'hFFFFFFFE, 0, 0, 0, 0));
    send_item(make_req(KIND_LOOKUP, 16'h1, 32'd10, 0, 0, 0, 0));
    send_item(make_req(KIND_LOOKUP, 16'h1, 32'd100, 0, 0, 0, 0));
    send_item(make_req(KIND_LOOKUP, 16'h1, 32'd149, 0, 0, 0, 0));
    send_item(make_req(KIND_LOOKUP, 16'h1, 32'd150, 0, 0, 0, 0));
    send_item(make_req(2'd3, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       24'hFFFFFF, 32'hFFFFFFFF));
    send_item(make_req(KIND_TICK, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    send_item(make_req(KIND_TICK, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    for (k = 0; k < 64; k++)
      send_item(make_req(KIND_INSERT, 16'(k), 0, 32'(k), 32'd4, 24'd70000, 0));
    send_item(make_req(KIND_INSERT, 16'h5, 0, 0, 0, 24'd1, 0));
    send_item(make_req(KIND_TICK, 0, 0, 0, 0, 0, 32'd3));
    write_budget(32'd0);
    send_item(make_req(KIND_TICK, 0, 0, 0, 0, 0, 32'd1));
    // random phases across budgets and idling mixes
    budgets[0] = 32'hFFFFFFFF; budgets[1] = 32'd500000;
    budgets[2] = BUDGET_RESET; budgets[3] = 32'd0;
    for (ph = 0; ph < 4; ph++) begin
      write_budget(budgets[ph] ^ (ph == 1 ? $urandom_range(255) : 0));
      send_idle = (ph == 1 || ph == 3) ? 85 : 0;
      recv_stall = (ph == 2) ? 85 : (ph == 3 ? 31 : 0);
      if (ph == 3) send_idle = 31;
      for (k = 0; k < 62; k++) send_item(rand_req());
    end
    req_valid <= 0;
    send_idle = 0; recv_stall = 0;
    k = 0;
    while (sb.pending.size() != 0 && k < 2000000) begin
      @(posedge clk);
      k++;
    end
    repeat (200) @(posedge clk);
    $display("covered %0d request items, %0d result items checked",
             items_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS byte_budget_chunk_cache_unit");
    else
      $display("FAIL byte_budget_chunk_cache_unit");
    $finish;
  end

  initial begin
    #400ms;
    $display("FAIL byte_budget_chunk_cache_unit");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bbc_core.sv
rtl/byte_budget_chunk_cache_unit.sv
sim/byte_budget_chunk_cache_unit_tb.sv
